// ===== src/fmid_pkg.sv =====
package fmid_pkg;

  localparam int GridSide = 7;
  localparam int CodeSide = 5;
  localparam int MaxWords = 5;
  localparam int RotCnt   = 4;

  localparam int CellW  = GridSide * GridSide;
  localparam int CodeW  = CodeSide * CodeSide;
  localparam int WordW  = CodeSide;
  localparam int CountW = 3;
  localparam int IdW    = 2 * CodeSide;
  localparam int RotW   = 2;
  localparam int RowDW  = 3;
  localparam int DistW  = 6;

  // row cost when the slot has no word in use; above any real row distance
  localparam logic [RowDW-1:0] NoWordDist = 3'd7;

  localparam logic [CountW-1:0] MaxWordsC = 3'd5;

  // configuration register indexes
  localparam logic [2:0] CfgSlot0  = 3'd0;
  localparam logic [2:0] CfgCounts = 3'd4;
  localparam logic [2:0] CfgActive = 3'd5;

  localparam logic [24:0] SlotWordsRst [4] = '{25'd15265, 25'd15638353,
                                              25'd28030665, 25'd10102931};
  localparam logic [11:0] CountsRst = 12'd2923;
  localparam logic [2:0]  ActiveRst = 3'd4;

  typedef enum logic [1:0] {
    StMatch   = 2'd0,
    StBorder  = 2'd1,
    StNoMatch = 2'd2
  } status_e;

  typedef logic [CodeW-1:0] code_t;

  function automatic logic [CellW-1:0] border_mask();
    logic [CellW-1:0] m;
    m = '0;
    for (int r = 0; r < GridSide; r++) begin
      for (int c = 0; c < GridSide; c++) begin
        if (r == 0 || r == GridSide - 1 || c == 0 || c == GridSide - 1) begin
          m[GridSide*r+c] = 1'b1;
        end
      end
    end
    return m;
  endfunction

  function automatic code_t extract_code(logic [CellW-1:0] cells);
    code_t m;
    m = '0;
    for (int r = 1; r <= CodeSide; r++) begin
      for (int c = 1; c <= CodeSide; c++) begin
        m[CodeSide*(r-1)+(c-1)] = cells[GridSide*r+c];
      end
    end
    return m;
  endfunction

  // clockwise quarter turn: out(i,j) = in(4-j, i)
  function automatic code_t turn_cw(code_t m);
    code_t r;
    r = '0;
    for (int i = 0; i < CodeSide; i++) begin
      for (int j = 0; j < CodeSide; j++) begin
        r[CodeSide*i+j] = m[CodeSide*(CodeSide-1-j)+i];
      end
    end
    return r;
  endfunction

  function automatic logic [RowDW-1:0] pop5(logic [WordW-1:0] v);
    logic [RowDW-1:0] n;
    n = '0;
    for (int i = 0; i < WordW; i++) begin
      n = n + RowDW'(v[i]);
    end
    return n;
  endfunction

  // row 0 in the top pair, column 1 above column 3
  function automatic logic [IdW-1:0] code_id(code_t m);
    logic [IdW-1:0] v;
    v = '0;
    for (int y = 0; y < CodeSide; y++) begin
      v[IdW-1-2*y] = m[CodeSide*y+1];
      v[IdW-2-2*y] = m[CodeSide*y+3];
    end
    return v;
  endfunction

endpackage

// ===== src/fiducial_marker_id_decode_top.sv =====
// channel | direction | handshake               | payload
// in      | input     | in_valid_i / in_ready_o   | cell_bits_i
// out     | output    | out_valid_o / out_ready_i | status_o, marker_id_o, rotation_o
// cfg     | input     | cfg_we_i                  | cfg_index_i, cfg_data_i
//
// one word per cycle while the output is not stalled; five register stages
// (border check and rotations, row distances, row sums, rotation pick, slot pick)
// reset clears the stage valid bits and loads the default word sets
// each stage holds its word while the next one is full and stalled, so a stall
// at the output backs up stage by stage and bubbles are squeezed out
module fiducial_marker_id_decode_top import fmid_pkg::*; #(
  parameter int NUM_SLOTS = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [CellW-1:0]   cell_bits_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         status_o,
  output logic [IdW-1:0]     marker_id_o,
  output logic [RotW-1:0]    rotation_o,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_index_i,
  input  logic [24:0]        cfg_data_i
);

  // configuration
  logic [CodeW-1:0] slot_words_q [NUM_SLOTS];
  logic [11:0]      counts_q;
  logic [2:0]       active_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < NUM_SLOTS; s++) begin
        slot_words_q[s] <= SlotWordsRst[s];
      end
      counts_q <= CountsRst;
      active_q <= ActiveRst;
    end else if (cfg_we_i) begin
      for (int s = 0; s < NUM_SLOTS; s++) begin
        if (cfg_index_i == CfgSlot0 + 3'(s)) begin
          slot_words_q[s] <= cfg_data_i;
        end
      end
      unique case (cfg_index_i)
        CfgCounts: counts_q <= cfg_data_i[11:0];
        CfgActive: active_q <= cfg_data_i[2:0];
        default: ;
      endcase
    end
  end

  // stage handshake
  logic v1_q, v2_q, v3_q, v4_q, v5_q;
  logic en1, en2, en3, en4, en5;

  assign en5 = !v5_q || out_ready_i;
  assign en4 = !v4_q || en5;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign in_ready_o = en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
      if (en5) v5_q <= v4_q;
    end
  end

  // stage 1: border check, inner code and its four turns
  code_t codes1_d [RotCnt];
  code_t codes1_q [RotCnt];
  logic  border1_d, border1_q;

  always_comb begin
    border1_d   = |(cell_bits_i & border_mask());
    codes1_d[0] = extract_code(cell_bits_i);
    for (int k = 1; k < RotCnt; k++) begin
      codes1_d[k] = turn_cw(codes1_d[k-1]);
    end
  end

  // stage 2: per slot, turn and row, the closest word
  logic [RowDW-1:0] rowd2_d [NUM_SLOTS][RotCnt][CodeSide];
  logic [RowDW-1:0] rowd2_q [NUM_SLOTS][RotCnt][CodeSide];
  code_t            codes2_q [RotCnt];
  logic             border2_q;

  always_comb begin
    logic [CountW-1:0] cnt;
    logic [WordW-1:0]  row;
    logic [RowDW-1:0]  best;
    logic [RowDW-1:0]  d;
    for (int s = 0; s < NUM_SLOTS; s++) begin
      cnt = counts_q[CountW*s +: CountW];
      if (cnt > MaxWordsC) cnt = MaxWordsC;
      for (int r = 0; r < RotCnt; r++) begin
        for (int y = 0; y < CodeSide; y++) begin
          row  = codes1_q[r][WordW*y +: WordW];
          best = NoWordDist;
          for (int w = 0; w < MaxWords; w++) begin
            d = pop5(row ^ slot_words_q[s][WordW*w +: WordW]);
            if (CountW'(w) < cnt && d < best) best = d;
          end
          rowd2_d[s][r][y] = best;
        end
      end
    end
  end

  // stage 3: code distance per slot and turn
  logic [DistW-1:0] dist3_d [NUM_SLOTS][RotCnt];
  logic [DistW-1:0] dist3_q [NUM_SLOTS][RotCnt];
  code_t            codes3_q [RotCnt];
  logic             border3_q;

  always_comb begin
    for (int s = 0; s < NUM_SLOTS; s++) begin
      for (int r = 0; r < RotCnt; r++) begin
        dist3_d[s][r] = '0;
        for (int y = 0; y < CodeSide; y++) begin
          dist3_d[s][r] = dist3_d[s][r] + DistW'(rowd2_q[s][r][y]);
        end
      end
    end
  end

  // stage 4: first strict minimum over the turns of each slot
  logic [RotW-1:0] bestr4_d [NUM_SLOTS];
  logic [RotW-1:0] bestr4_q [NUM_SLOTS];
  logic            hit4_d   [NUM_SLOTS];
  logic            hit4_q   [NUM_SLOTS];
  code_t           codes4_q [RotCnt];
  logic            border4_q;

  always_comb begin
    logic [DistW-1:0] bd;
    for (int s = 0; s < NUM_SLOTS; s++) begin
      bd          = dist3_q[s][0];
      bestr4_d[s] = '0;
      for (int r = 1; r < RotCnt; r++) begin
        if (dist3_q[s][r] < bd) begin
          bd          = dist3_q[s][r];
          bestr4_d[s] = RotW'(r);
        end
      end
      hit4_d[s] = (bd == '0);
    end
  end

  // stage 5: first matching slot among the active ones
  status_e         status5_d, status5_q;
  logic [IdW-1:0]  id5_d, id5_q;
  logic [RotW-1:0] rot5_d, rot5_q;

  always_comb begin
    logic [2:0] nslots;
    logic       found;
    nslots = (active_q > 3'(NUM_SLOTS)) ? 3'(NUM_SLOTS) : active_q;
    found  = 1'b0;
    rot5_d = '0;
    for (int s = 0; s < NUM_SLOTS; s++) begin
      if (!found && 3'(s) < nslots) begin
        rot5_d = bestr4_q[s];
        if (hit4_q[s]) found = 1'b1;
      end
    end
    if (border4_q) begin
      status5_d = StBorder;
      id5_d     = '0;
      rot5_d    = '0;
    end else if (found) begin
      status5_d = StMatch;
      id5_d     = code_id(codes4_q[rot5_d]);
    end else begin
      status5_d = StNoMatch;
      id5_d     = '0;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (en1) begin
      codes1_q  <= codes1_d;
      border1_q <= border1_d;
    end
    if (en2) begin
      rowd2_q   <= rowd2_d;
      codes2_q  <= codes1_q;
      border2_q <= border1_q;
    end
    if (en3) begin
      dist3_q   <= dist3_d;
      codes3_q  <= codes2_q;
      border3_q <= border2_q;
    end
    if (en4) begin
      bestr4_q  <= bestr4_d;
      hit4_q    <= hit4_d;
      codes4_q  <= codes3_q;
      border4_q <= border3_q;
    end
    if (en5) begin
      status5_q <= status5_d;
      id5_q     <= id5_d;
      rot5_q    <= rot5_d;
    end
  end

  assign out_valid_o = v5_q;
  assign status_o    = status5_q;
  assign marker_id_o = id5_q;
  assign rotation_o  = rot5_q;

  // the input only backs up when every stage holds a word
  a_full_pipe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (v1_q && v2_q && v3_q && v4_q && v5_q && !out_ready_i))
    else $error("input stalled with room in the pipeline");

  a_border_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == StBorder |-> marker_id_o == '0 && rotation_o == '0)
    else $error("border fail with nonzero id or rotation");

  a_nomatch_id: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == StNoMatch |-> marker_id_o == '0)
    else $error("no match with nonzero id");

  a_stage_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v4_q && en5 |=> v5_q)
    else $error("word lost between rotation pick and output");

endmodule
